FILE: rtl/core/idv_pkg.sv
package idv_pkg;

  localparam int unsigned IdLength = 18;
  localparam int unsigned PosW     = 5;
  localparam logic [PosW-1:0] PosSat = PosW'(IdLength + 1);
  localparam int unsigned YearW    = 14;
  localparam logic [YearW-1:0] MaxYearReset = YearW'(2025);
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  typedef enum logic [2:0] {
    StatusValid     = 3'd0,
    StatusBadLength = 3'd1,
    StatusBadChar   = 3'd2,
    StatusYearLate  = 3'd3,
    StatusBadLeap   = 3'd4,
    StatusBadCheck  = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    RegMaxBirthYear = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_marker;
  } in_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       is_valid;
  } out_rsp_t;

  function automatic logic [3:0] weight(input logic [PosW-1:0] pos);
    logic [3:0] w;
    unique case (pos)
      5'd0:    w = 4'd7;
      5'd1:    w = 4'd9;
      5'd2:    w = 4'd10;
      5'd3:    w = 4'd5;
      5'd4:    w = 4'd8;
      5'd5:    w = 4'd4;
      5'd6:    w = 4'd2;
      5'd7:    w = 4'd1;
      5'd8:    w = 4'd6;
      5'd9:    w = 4'd3;
      5'd10:   w = 4'd7;
      5'd11:   w = 4'd9;
      5'd12:   w = 4'd10;
      5'd13:   w = 4'd5;
      5'd14:   w = 4'd8;
      5'd15:   w = 4'd4;
      5'd16:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] check_char(input logic [3:0] sum);
    logic [7:0] c;
    unique case (sum)
      4'd0:    c = "1";
      4'd1:    c = "0";
      4'd2:    c = "X";
      4'd3:    c = "9";
      4'd4:    c = "8";
      4'd5:    c = "7";
      4'd6:    c = "6";
      4'd7:    c = "5";
      4'd8:    c = "4";
      4'd9:    c = "3";
      4'd10:   c = "2";
      default: c = "1";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] leap_char(input logic [PosW-1:0] pos);
    logic [7:0] c;
    unique case (pos)
      5'd10:   c = "0";
      5'd11:   c = "2";
      5'd12:   c = "2";
      default: c = "9";
    endcase
    return c;
  endfunction

  // x mod 11 for x <= 127 via reciprocal 187/2048
  function automatic logic [3:0] mod11(input logic [6:0] x);
    logic [14:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = 15'(x) * 15'd187;
    q = p[14:11];
    r = x - 7'(q * 7'd11);
    return r[3:0];
  endfunction

endpackage

FILE: rtl/core/id_number_check_digit_validator.sv
// A terminator request's status is registered and appears in the cycle after acceptance.
// Throughput: one character or terminator request per cycle; input stalls only
// while a status waits in the output register and out_ready_i is low.
// Reset (rst_ni low, asynchronous): per-string state cleared except pair_q and
// cent_q, output empty, max_birth_year back to 2025.
module id_number_check_digit_validator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  idv_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output idv_pkg::out_rsp_t             out_rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [idv_pkg::AddrW-1:0]     paddr,
  input  logic [idv_pkg::DataW-1:0]     pwdata,
  output logic [idv_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  localparam int unsigned PosW  = idv_pkg::PosW;
  localparam int unsigned YearW = idv_pkg::YearW;

  logic [YearW-1:0] max_year_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [3:0]       sum_q, sum_d;
  logic             bad_q, bad_d;
  logic [YearW-1:0] year_q, year_d;
  logic [6:0]       pair_q, pair_d;
  logic [6:0]       cent_q, cent_d;
  logic             leap_match_q, leap_match_d;
  logic             check_q, check_d;
  logic             out_valid_q;
  idv_pkg::out_rsp_t out_rsp_q;

  logic             accept;
  logic             cfg_wr;
  logic [7:0]       c;
  logic             digit;
  logic [3:0]       dv;
  logic [6:0]       prod;
  logic [6:0]       pair_ext;
  logic [7:0]       want;
  logic             leap;
  idv_pkg::status_e status;

  assign pready     = 1'b1;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign prdata     = (paddr[2] == idv_pkg::RegMaxBirthYear) ?
                      idv_pkg::DataW'(max_year_q) : '0;

  assign c        = in_req_i.char_code;
  assign digit    = (c >= "0") && (c <= "9");
  assign dv       = digit ? c[3:0] : 4'd0;
  assign prod     = 7'(dv) * 7'(idv_pkg::weight(pos_q));
  assign pair_ext = 7'(pair_q * 7'd10) + 7'(dv);
  assign want     = idv_pkg::check_char(sum_q);

  always_comb begin
    pos_d        = pos_q;
    sum_d        = sum_q;
    bad_d        = bad_q;
    year_d       = year_q;
    pair_d       = pair_q;
    cent_d       = cent_q;
    leap_match_d = leap_match_q;
    check_d      = check_q;
    if (pos_q < PosW'(idv_pkg::IdLength - 1)) begin
      if (!digit) begin
        bad_d = 1'b1;
      end
      sum_d  = idv_pkg::mod11(7'(sum_q) + prod);
      if (pos_q >= 5'd6 && pos_q <= 5'd9) begin
        year_d = YearW'(year_q * YearW'(10)) + YearW'(dv);
        if (pos_q == 5'd6 || pos_q == 5'd8) begin
          pair_d = 7'(dv);
        end else begin
          pair_d = pair_ext;
        end
        if (pos_q == 5'd7) begin
          cent_d = pair_ext;
        end
      end
      if (pos_q >= 5'd10 && pos_q <= 5'd13 && c != idv_pkg::leap_char(pos_q)) begin
        leap_match_d = 1'b0;
      end
    end else if (pos_q == PosW'(idv_pkg::IdLength - 1)) begin
      if (!digit && c != "x" && c != "X") begin
        bad_d = 1'b1;
      end
      if (want == "X") begin
        check_d = (c == "X") || (c == "x");
      end else begin
        check_d = (c == want);
      end
    end
    if (pos_q < idv_pkg::PosSat) begin
      pos_d = pos_q + PosW'(1);
    end
  end

  // year is four decimal digits: century pair in cent_q, last pair in pair_q
  assign leap = (pair_q == 7'd0) ? (cent_q[1:0] == 2'b00) : (pair_q[1:0] == 2'b00);

  always_comb begin
    priority if (pos_q != PosW'(idv_pkg::IdLength)) begin
      status = idv_pkg::StatusBadLength;
    end else if (bad_q) begin
      status = idv_pkg::StatusBadChar;
    end else if (year_q > max_year_q) begin
      status = idv_pkg::StatusYearLate;
    end else if (leap_match_q && !leap) begin
      status = idv_pkg::StatusBadLeap;
    end else if (!check_q) begin
      status = idv_pkg::StatusBadCheck;
    end else begin
      status = idv_pkg::StatusValid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_year_q <= idv_pkg::MaxYearReset;
    end else if (cfg_wr && paddr[2] == idv_pkg::RegMaxBirthYear) begin
      max_year_q <= pwdata[YearW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      sum_q        <= '0;
      bad_q        <= 1'b0;
      year_q       <= '0;
      leap_match_q <= 1'b1;
      check_q      <= 1'b0;
    end else if (accept) begin
      if (in_req_i.end_marker) begin
        pos_q        <= '0;
        sum_q        <= '0;
        bad_q        <= 1'b0;
        year_q       <= '0;
        leap_match_q <= 1'b1;
        check_q      <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        sum_q        <= sum_d;
        bad_q        <= bad_d;
        year_q       <= year_d;
        leap_match_q <= leap_match_d;
        check_q      <= check_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !in_req_i.end_marker) begin
      pair_q <= pair_d;
      cent_q <= cent_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && in_req_i.end_marker) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_req_i.end_marker) begin
      out_rsp_q.status   <= status;
      out_rsp_q.is_valid <= (status == idv_pkg::StatusValid);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

class idv_scoreboard;
  logic [idv_pkg::YearW-1:0] max_year;
  logic [idv_pkg::PosW-1:0]  pos;
  logic [3:0]                sum_mod;
  logic                      bad_char;
  logic [idv_pkg::YearW-1:0] year;
  logic                      leap_match;
  logic                      check_ok;
  idv_pkg::out_rsp_t         status_q[$];
  int                        errors;
  logic [3:0]                weights[17];
  logic [7:0]                check_chars[11];
  logic [7:0]                leap_chars[4];

  function new();
    weights     = '{7, 9, 10, 5, 8, 4, 2, 1, 6, 3, 7, 9, 10, 5, 8, 4, 2};
    check_chars = '{"1", "0", "X", "9", "8", "7", "6", "5", "4", "3", "2"};
    leap_chars  = '{"0", "2", "2", "9"};
    max_year    = idv_pkg::MaxYearReset;
    errors      = 0;
    clear_string();
  endfunction

  function void clear_string();
    pos        = '0;
    sum_mod    = '0;
    bad_char   = 1'b0;
    year       = '0;
    leap_match = 1'b1;
    check_ok   = 1'b0;
  endfunction

  function bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function logic [7:0] good_check(logic [7:0] s[$]);
    int unsigned sum;
    sum = 0;
    for (int i = 0; i < 17; i++) begin
      sum = (sum + (s[i] - "0") * weights[i]) % 11;
    end
    return check_chars[sum];
  endfunction

  function int pending();
    return status_q.size();
  endfunction

  function void note_request(idv_pkg::in_req_t r);
    logic [7:0]        c;
    logic [7:0]        want;
    bit                dig;
    int unsigned       dv;
    idv_pkg::status_e  st;
    idv_pkg::out_rsp_t o;
    c = r.char_code;
    if (r.end_marker) begin
      if (pos != idv_pkg::IdLength) st = idv_pkg::StatusBadLength;
      else if (bad_char) st = idv_pkg::StatusBadChar;
      else if (year > max_year) st = idv_pkg::StatusYearLate;
      else if (leap_match && !leap_year(year)) st = idv_pkg::StatusBadLeap;
      else if (!check_ok) st = idv_pkg::StatusBadCheck;
      else st = idv_pkg::StatusValid;
      o.status   = st;
      o.is_valid = (st == idv_pkg::StatusValid);
      status_q.push_back(o);
      clear_string();
      return;
    end
    dig = (c >= "0") && (c <= "9");
    dv  = dig ? c - "0" : 0;
    if (pos < idv_pkg::IdLength - 1) begin
      if (!dig) bad_char = 1'b1;
      sum_mod = 4'((sum_mod + dv * weights[pos]) % 11);
      if (pos >= 6 && pos <= 9) year = idv_pkg::YearW'(year * 10 + dv);
      if (pos >= 10 && pos <= 13 && c != leap_chars[pos - 10]) leap_match = 1'b0;
    end else if (pos == idv_pkg::IdLength - 1) begin
      want = check_chars[sum_mod];
      if (!dig && c != "x" && c != "X") bad_char = 1'b1;
      check_ok = (want == "X") ? (c == "X" || c == "x") : (c == want);
    end
    if (pos < idv_pkg::PosSat) pos = pos + 1'b1;
  endfunction

  function void check_status(idv_pkg::out_rsp_t got);
    idv_pkg::out_rsp_t exp;
    if (status_q.size() == 0) begin
      $error("status: no result expected, got %0d", got.status);
      errors++;
      return;
    end
    exp = status_q.pop_front();
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      errors++;
    end
    if (got.is_valid !== exp.is_valid) begin
      $error("is_valid: expected %0d, got %0d", exp.is_valid, got.is_valid);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int unsigned PhaseItems = 145;
  localparam int unsigned StallLimit = 5000;

  typedef enum {RdyAlways, RdyCoin, RdyQuarter, RdySparse} rdy_mode_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  idv_pkg::in_req_t           in_req_i;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  idv_pkg::out_rsp_t          out_rsp_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [idv_pkg::AddrW-1:0]  paddr;
  logic [idv_pkg::DataW-1:0]  pwdata;
  logic [idv_pkg::DataW-1:0]  prdata;
  logic                       pready;

  idv_scoreboard sb;
  int unsigned   burst_left;
  int unsigned   items_sent;
  int unsigned   stall_cycles;
  rdy_mode_e     rdy_mode = RdyAlways;
  int unsigned   rdy_left = 0;

  id_number_check_digit_validator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode <= rdy_mode_e'($urandom_range(0, 3));
      rdy_left <= $urandom_range(20, 80);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      RdyAlways:  out_ready_i <= 1'b1;
      RdyCoin:    out_ready_i <= 1'($urandom_range(0, 1));
      RdyQuarter: out_ready_i <= (rdy_left[1:0] == 2'd0);
      default:    out_ready_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_status(out_rsp_o);
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] c, input logic last);
    idv_pkg::in_req_t r;
    int unsigned      gap;
    r.char_code  = c;
    r.end_marker = last;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(negedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_id(input logic [7:0] s[$]);
    foreach (s[i]) send_item(s[i], 1'b0);
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // setup + access write, then a read back of the same register
  task automatic write_max_year(input logic [idv_pkg::DataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= idv_pkg::AddrW'(4 * idv_pkg::RegMaxBirthYear);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.max_year = v[idv_pkg::YearW-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[idv_pkg::YearW-1:0] !== sb.max_year) begin
      $error("max_birth_year: expected %0d, got %0d", sb.max_year,
             prdata[idv_pkg::YearW-1:0]);
      sb.errors++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_id(input logic [idv_pkg::YearW-1:0] lim, output logic [7:0] s[$]);
    int unsigned kind, yr, n, p, lim_y;
    logic [7:0]  c;
    int unsigned leap_years[6] = '{2000, 1900, 2024, 2023, 0, 2100};
    s     = {};
    kind  = $urandom_range(0, 99);
    lim_y = (lim > 9999) ? 9999 : lim;
    if (kind >= 90) begin
      n = $urandom_range(0, 22);
      repeat (n) s.push_back(8'($urandom));
      return;
    end
    case ($urandom_range(0, 4))
      0:       yr = $urandom_range(0, 9999);
      1:       yr = lim_y;
      2:       yr = (lim_y < 9999) ? lim_y + 1 : 9998;
      3:       yr = leap_years[$urandom_range(0, 5)];
      default: yr = $urandom_range(0, lim_y);
    endcase
    repeat (17) s.push_back(8'("0" + $urandom_range(0, 9)));
    s[6] = 8'("0" + yr / 1000);
    s[7] = 8'("0" + (yr / 100) % 10);
    s[8] = 8'("0" + (yr / 10) % 10);
    s[9] = 8'("0" + yr % 10);
    if ($urandom_range(0, 1)) begin
      s[10] = "0";
      s[11] = "2";
      s[12] = "2";
      s[13] = "9";
      if ($urandom_range(0, 4) == 0) s[10 + $urandom_range(0, 3)] = "1";
    end
    c = sb.good_check(s);
    if (c == "X" && $urandom_range(0, 1)) c = "x";
    s.push_back(c);
    if (kind >= 55 && kind < 70) begin
      s[17] = $urandom_range(0, 1) ? 8'("0" + $urandom_range(0, 9)) : 8'($urandom);
    end else if (kind >= 70 && kind < 80) begin
      p = $urandom_range(0, 17);
      case ($urandom_range(0, 3))
        0:       s[p] = 8'h00;
        1:       s[p] = 8'($urandom);
        2:       s[p] = "x";
        default: s[p] = $urandom_range(0, 1) ? "/" : ":";
      endcase
    end else if (kind >= 80) begin
      if ($urandom_range(0, 1)) begin
        n = $urandom_range(0, 17);
        while (s.size() > n) void'(s.pop_back());
      end else begin
        repeat ($urandom_range(1, 5)) s.push_back(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0]                s[$];
    string                     body;
    logic [idv_pkg::DataW-1:0] phase_cfg[6];
    int unsigned               start;
    sb         = new();
    burst_left = 0;
    items_sent = 0;
    stall_cycles = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty string, a valid leap-day id, a lone NUL byte
    send_item(8'h00, 1'b1);
    body = "11010520000229123";
    s = {};
    for (int i = 0; i < body.len(); i++) s.push_back(body[i]);
    s.push_back(sb.good_check(s));
    send_id(s);
    s = {8'h00};
    send_id(s);
    settle();

    phase_cfg = '{32'd9999, 32'd0, 32'd1987, 32'hFFFF_FFFF, $urandom, 32'd2025};
    foreach (phase_cfg[k]) begin
      write_max_year(phase_cfg[k]);
      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        random_id(sb.max_year, s);
        send_id(s);
      end
      settle();
    end

    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
